// ===== sv/sasf_pkg.sv =====
// Shared types and constants for the smooth abs / sort / fold pipeline.
// Used by smooth_abs_sort_fold_unit; no dependencies.
package sasf_pkg;

  // Fixed-point formats
  localparam int COORD_FRAC_BITS = 16;
  localparam int GAIN_FRAC_BITS  = 12;
  localparam int SH_UP = (COORD_FRAC_BITS >= GAIN_FRAC_BITS) ?
                         COORD_FRAC_BITS - GAIN_FRAC_BITS : 0;
  localparam int SH_DN = (GAIN_FRAC_BITS > COORD_FRAC_BITS) ?
                         GAIN_FRAC_BITS - COORD_FRAC_BITS : 0;

  // Square root: 32 result bits, SQ_STEPS bits per pipeline stage
  localparam int SQ_STEPS  = 4;
  localparam int SQ_STAGES = 32 / SQ_STEPS;

  // Stage map
  localparam int ST_IN     = 0;
  localparam int ST_MUL    = 1;
  localparam int ST_RAD    = 2;
  localparam int ST_SQ0    = 3;
  localparam int ST_ABS    = ST_SQ0 + SQ_STAGES;
  localparam int SORT_BASE = ST_ABS + 1;
  localparam int SORT_LEN  = 4 + SQ_STAGES;
  localparam int ST_ADD    = SORT_BASE + 3 * SORT_LEN;
  localparam int NUM_ST    = ST_ADD + 1;

  // Configuration register indexes
  localparam logic [2:0] REG_SMOOTH_OFFSET = 3'd0;
  localparam logic [2:0] REG_ABS_GAIN      = 3'd1;
  localparam logic [2:0] REG_SORT_GAIN     = 3'd2;
  localparam logic [2:0] REG_SORT_MASK     = 3'd3;
  localparam logic [2:0] REG_ADD_OFF_X     = 3'd4;
  localparam logic [2:0] REG_ADD_OFF_Y     = 3'd5;
  localparam logic [2:0] REG_ADD_OFF_Z     = 3'd6;

  typedef struct packed {
    logic [30:0]       smooth_offset;
    logic [47:0]       abs_gain;
    logic [47:0]       sort_gain;
    logic [2:0]        sort_mask;
    logic [2:0][31:0]  add_off;
  } cfg_t;

  // Root working set
  typedef struct packed {
    logic [63:0] rad;
    logic [33:0] rem;
    logic [31:0] root;
  } sq_t;

  // One pipeline word
  typedef struct packed {
    logic [2:0][31:0] c;
    logic [31:0]      w;
    logic [2:0][31:0] av;
    logic [32:0]      d;
    logic [31:0]      ud;
    logic [2:0][47:0] gm;
    logic [2:0][63:0] rad;
    logic [2:0][33:0] rem;
    logic [2:0][31:0] root;
  } pl_t;

endpackage

// ===== sv/smooth_abs_sort_fold_unit.sv =====
// Top level of the smooth abs / smooth sort / offset fold pipeline.
// Depends on sasf_pkg for types, stage map and register indexes.
//
//  channel | direction | handshake           | payload
//  in_     | slave     | in_tvalid/in_tready | in_tdata  128 bit: x, y, z, w
//  out_    | master    | out_tvalid/tready   | out_tdata 128 bit: x, y, z, w
//  cfg_    | slave     | cfg_valid/cfg_ready | cfg_index 3 bit, cfg_data 48 bit
//
// One word enters per cycle while out_tready is high or the last stage is empty.
// There are 49 register stages; depth is set by the four integer square roots in series
// (abs, then three sort steps), each an 8-stage pipeline resolving 4 root bits per stage.
// Reset (rst_n low, synchronous) clears all valid bits and loads register defaults.
// A stall on out_tready freezes every stage together; nothing is dropped.
module smooth_abs_sort_fold_unit (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [127:0] in_tdata,   // x [31:0], y [63:32], z [95:64], w [127:96]
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [127:0] out_tdata,  // x [31:0], y [63:32], z [95:64], w [127:96]
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [2:0]   cfg_index,
  input  logic [47:0]  cfg_data
);
  import sasf_pkg::*;

  cfg_t              cfg_r;
  pl_t               pipe_r   [NUM_ST];
  pl_t               pipe_nxt [NUM_ST];
  logic [NUM_ST-1:0] vld_r;
  logic              adv;
  pl_t               in_word;

  // Saturate to the signed 32-bit range
  function automatic logic [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
    if (v < -64'sd2147483648) return 32'h8000_0000;
    return v[31:0];
  endfunction

  function automatic logic [15:0] gain_of(input logic [47:0] packed_g, input int i);
    return packed_g[16*i +: 16];
  endfunction

  function automatic logic [15:0] mag16(input logic [15:0] g);
    return g[15] ? (~g + 16'd1) : g;
  endfunction

  // sq + offset +/- |v|*gain at 2*COORD_FRAC_BITS fraction bits, saturating
  function automatic logic [63:0] rad_fn(input logic [63:0] sq, input logic [47:0] gm,
                                         input logic gneg, input logic [30:0] offs);
    logic [64:0] s1;
    logic [64:0] s2;
    logic [95:0] wide;
    logic [63:0] acc;
    logic [63:0] m;
    s1   = {1'b0, sq} + {1'b0, 64'(offs) << COORD_FRAC_BITS};
    acc  = s1[64] ? '1 : s1[63:0];
    wide = ({48'b0, gm} << SH_UP) >> SH_DN;
    m    = (|wide[95:64]) ? '1 : wide[63:0];
    s2   = {1'b0, acc} + {1'b0, m};
    if (gneg) return (acc > m) ? acc - m : 64'd0;
    return s2[64] ? '1 : s2[63:0];
  endfunction

  // SQ_STEPS digits of the restoring square root
  function automatic sq_t sq_steps(input sq_t a);
    sq_t         q;
    logic [35:0] tmp;
    logic [35:0] trial;
    q = a;
    for (int i = 0; i < SQ_STEPS; i++) begin
      tmp   = {q.rem, q.rad[63:62]};
      trial = {2'b00, q.root, 2'b01};
      if (tmp >= trial) begin
        tmp    = tmp - trial;
        q.root = {q.root[30:0], 1'b1};
      end else begin
        q.root = {q.root[30:0], 1'b0};
      end
      q.rem = tmp[33:0];
      q.rad = {q.rad[61:0], 2'b00};
    end
    return q;
  endfunction

  // Work done by pipeline stage k
  function automatic pl_t stage_fn(input int k, input pl_t p, input cfg_t cf);
    pl_t                q;
    sq_t                sq;
    logic [15:0]        g;
    logic signed [63:0] yv;
    logic signed [63:0] va;
    logic signed [63:0] vb;
    logic signed [63:0] t;
    logic signed [33:0] x;
    logic [47:0]        my;
    int                 b;
    int                 ia;
    int                 ib;
    q = p;
    if (k == ST_IN) begin
      for (int i = 0; i < 3; i++) q.av[i] = p.c[i][31] ? -p.c[i] : p.c[i];
    end else if (k == ST_MUL) begin
      for (int i = 0; i < 3; i++) begin
        q.rad[i] = 64'(p.av[i]) * 64'(p.av[i]);
        q.gm[i]  = 48'(p.av[i]) * 48'(mag16(gain_of(cf.abs_gain, i)));
      end
    end else if (k == ST_RAD) begin
      for (int i = 0; i < 3; i++) begin
        g = gain_of(cf.abs_gain, i);
        if (i == 1) q.rad[i] = rad_fn(p.rad[i], '0, 1'b0, cf.smooth_offset);
        else        q.rad[i] = rad_fn(p.rad[i], p.gm[i], g[15], cf.smooth_offset);
        q.rem[i]  = '0;
        q.root[i] = '0;
      end
    end else if (k >= ST_SQ0 && k < ST_SQ0 + SQ_STAGES) begin
      for (int i = 0; i < 3; i++) begin
        sq = sq_steps('{rad: p.rad[i], rem: p.rem[i], root: p.root[i]});
        q.rad[i]  = sq.rad;
        q.rem[i]  = sq.rem;
        q.root[i] = sq.root;
      end
    end else if (k == ST_ABS) begin
      // y takes its gain term after the root
      g  = gain_of(cf.abs_gain, 1);
      my = p.gm[1] >> GAIN_FRAC_BITS;
      yv = g[15] ? $signed(64'(p.root[1])) - $signed(64'(my))
                 : $signed(64'(p.root[1])) + $signed(64'(my));
      q.c[0] = sat32($signed(64'(p.root[0])));
      q.c[1] = sat32(yv);
      q.c[2] = sat32($signed(64'(p.root[2])));
    end else if (k == ST_ADD) begin
      for (int i = 0; i < 3; i++) begin
        q.c[i] = sat32(64'($signed(p.c[i])) + 64'($signed(cf.add_off[i])));
      end
    end else begin
      // Smooth sort steps on (x,y), (y,z), (z,x)
      for (int s = 0; s < 3; s++) begin
        b  = SORT_BASE + s * SORT_LEN;
        ia = s;
        ib = (s == 2) ? 0 : s + 1;
        g  = gain_of(cf.sort_gain, s);
        if (k == b) begin
          q.d     = 33'($signed(p.c[ia])) - 33'($signed(p.c[ib]));
          q.ud    = q.d[32] ? 32'(-q.d) : q.d[31:0];
          q.gm[0] = 48'(p.av[s]) * 48'(mag16(g));
        end else if (k == b + 1) begin
          q.rad[0] = 64'(p.ud) * 64'(p.ud);
        end else if (k == b + 2) begin
          q.rad[0]  = rad_fn(p.rad[0], p.gm[0], g[15], cf.smooth_offset);
          q.rem[0]  = '0;
          q.root[0] = '0;
        end else if (k >= b + 3 && k < b + 3 + SQ_STAGES) begin
          sq = sq_steps('{rad: p.rad[0], rem: p.rem[0], root: p.root[0]});
          q.rad[0]  = sq.rad;
          q.rem[0]  = sq.rem;
          q.root[0] = sq.root;
        end else if (k == b + 3 + SQ_STAGES) begin
          if (cf.sort_mask[s]) begin
            x  = 34'($signed(p.d)) - $signed({2'b00, p.root[0]});
            t  = 64'(x >>> 1);
            va = 64'($signed(p.c[ia]));
            vb = 64'($signed(p.c[ib]));
            q.c[ia] = sat32(va - t);
            q.c[ib] = sat32(vb + t);
          end
        end
      end
    end
    return q;
  endfunction

  // Advance all stages together unless the output word is held
  assign adv        = !vld_r[NUM_ST-1] || out_tready;
  assign in_tready  = adv;
  assign out_tvalid = vld_r[NUM_ST-1];
  assign out_tdata  = {pipe_r[NUM_ST-1].w, pipe_r[NUM_ST-1].c};
  assign cfg_ready  = 1'b1;

  // Unpack the input word
  always_comb begin
    in_word   = '0;
    in_word.c = in_tdata[95:0];
    in_word.w = in_tdata[127:96];
  end

  // Stage logic
  for (genvar k = 0; k < NUM_ST; k++) begin : g_stage
    if (k == 0) begin : g_first
      always_comb pipe_nxt[k] = stage_fn(k, in_word, cfg_r);
    end else begin : g_rest
      always_comb pipe_nxt[k] = stage_fn(k, pipe_r[k-1], cfg_r);
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < NUM_ST; k++) pipe_r[k] <= pipe_nxt[k];
    end
  end

  // Valid bits travel with the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[NUM_ST-2:0], in_tvalid};
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.smooth_offset <= 31'd328;
      cfg_r.abs_gain      <= '0;
      cfg_r.sort_gain     <= '0;
      cfg_r.sort_mask     <= '0;
      cfg_r.add_off       <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_SMOOTH_OFFSET: cfg_r.smooth_offset <= cfg_data[30:0];
        REG_ABS_GAIN:      cfg_r.abs_gain      <= cfg_data;
        REG_SORT_GAIN:     cfg_r.sort_gain     <= cfg_data;
        REG_SORT_MASK:     cfg_r.sort_mask     <= cfg_data[2:0];
        REG_ADD_OFF_X:     cfg_r.add_off[0]    <= cfg_data[31:0];
        REG_ADD_OFF_Y:     cfg_r.add_off[1]    <= cfg_data[31:0];
        REG_ADD_OFF_Z:     cfg_r.add_off[2]    <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

endmodule

// ===== sv/sasf_checker.sv =====
// Port-level checks for smooth_abs_sort_fold_unit, bound to the top level.
// Sees only the top level's ports; no package needed.
module sasf_checker (
  input logic         clk,
  input logic         rst_n,
  input logic         in_tvalid,
  input logic         in_tready,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [127:0] out_tdata,
  input logic         cfg_valid,
  input logic         cfg_ready
);

  // A held result word keeps its data
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("output word changed while stalled");

  // Input side is open whenever the output side drains
  a_ready_follow: assert property (@(posedge clk) disable iff (!rst_n)
    out_tready |-> in_tready)
    else $error("input stalled while output drains");

  // An empty output stage never blocks the input
  a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with no output word pending");

  // Reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid right after reset");

  // Register writes are always taken
  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid |-> cfg_ready)
    else $error("configuration write refused");

endmodule

bind smooth_abs_sort_fold_unit sasf_checker u_sasf_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .cfg_valid  (cfg_valid),
  .cfg_ready  (cfg_ready)
);
